[rtl/core/tccw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned DATA_W = 16;
  // wide enough for any row * columns + column of the largest screen
  localparam int unsigned LIN_W  = 12;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEEK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] ATTR_NORMAL  = 8'h0F;
  localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0F20;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  seek_col;
    logic [ROW_W-1:0]  seek_row;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [DATA_W-1:0] read_data;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_TAB,
    OP_SEEK,
    OP_READ,
    OP_NONE
  } op_e;

  // lin carries the clamped seek position or the cell index of a read
  typedef struct packed {
    op_e               kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [LIN_W-1:0]  lin;
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SCROLL
  } back_state_e;

endpackage

[rtl/core/tccw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tccw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Input side: takes commands and decodes them into console operations.
// ----------------------------------------------------------------------------
module tccw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tccw_pkg::in_item_t in_item_i,
  input  logic               init_done_i,
  input  logic               q_full_i,
  output logic               push_o,
  output tccw_pkg::op_t      op_o
);

  localparam int unsigned LIN_W = tccw_pkg::LIN_W;
  localparam logic [tccw_pkg::COL_W-1:0] ColLast = tccw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tccw_pkg::ROW_W-1:0] RowLast = tccw_pkg::ROW_W'(ROWS - 1);
  localparam logic [LIN_W:0] CellCount = (LIN_W + 1)'(COLUMNS * ROWS);

  logic [tccw_pkg::COL_W-1:0] col_c;
  logic [tccw_pkg::ROW_W-1:0] row_c;

  assign in_stall_o = q_full_i || !init_done_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign col_c = (in_item_i.seek_col > ColLast) ? ColLast : in_item_i.seek_col;
  assign row_c = (in_item_i.seek_row > RowLast) ? RowLast : in_item_i.seek_row;

  always_comb begin
    op_o.kind      = tccw_pkg::OP_NONE;
    op_o.char_code = in_item_i.char_code;
    op_o.col       = col_c;
    op_o.row       = row_c;
    op_o.lin       = LIN_W'(row_c) * LIN_W'(COLUMNS) + LIN_W'(col_c);
    unique case (in_item_i.command)
      tccw_pkg::CMD_PUT: begin
        if (in_item_i.char_code == tccw_pkg::CHAR_NEWLINE) begin
          op_o.kind = tccw_pkg::OP_NEWLINE;
        end else if (in_item_i.char_code == tccw_pkg::CHAR_TAB) begin
          op_o.kind = tccw_pkg::OP_TAB;
        end else begin
          op_o.kind = tccw_pkg::OP_PUT;
        end
      end
      tccw_pkg::CMD_SEEK: begin
        op_o.kind = tccw_pkg::OP_SEEK;
      end
      tccw_pkg::CMD_READ: begin
        op_o.lin = LIN_W'(in_item_i.cell_index);
        // reads past the screen return zero
        if ((LIN_W + 1)'(in_item_i.cell_index) < CellCount) begin
          op_o.kind = tccw_pkg::OP_READ;
        end
      end
      default: begin
        op_o.kind = tccw_pkg::OP_NONE;
      end
    endcase
  end

endmodule

[rtl/core/tccw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue
// Short FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module tccw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tccw_pkg::op_t op_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output tccw_pkg::op_t op_o
);

  localparam int unsigned QPTR_W = tccw_pkg::QPTR_W;
  localparam int unsigned QCNT_W = tccw_pkg::QCNT_W;

  tccw_pkg::op_t     entry_q [tccw_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(tccw_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

[rtl/core/tccw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Execution side: owns the cursor and the screen RAM, runs the clearing
// sweeps and drives the result register.
// ----------------------------------------------------------------------------
module tccw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tccw_pkg::op_t       q_op_i,
  output logic                pop_o,
  output logic                init_done_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tccw_pkg::out_item_t out_item_o
);

  localparam int unsigned LIN_W  = tccw_pkg::LIN_W;
  localparam int unsigned COL_W  = tccw_pkg::COL_W;
  localparam int unsigned ROW_W  = tccw_pkg::ROW_W;
  localparam int unsigned POS_W  = tccw_pkg::POS_W;
  localparam int unsigned DATA_W = tccw_pkg::DATA_W;
  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned AW     = $clog2(CELLS);

  localparam logic [LIN_W:0]   CellCount = (LIN_W + 1)'(CELLS);
  localparam logic [LIN_W-1:0] CellLast  = LIN_W'(CELLS - 1);
  localparam logic [LIN_W-1:0] Cols      = LIN_W'(COLUMNS);
  localparam logic [LIN_W-1:0] BottomLin = LIN_W'((ROWS - 1) * COLUMNS);
  localparam logic [LIN_W-1:0] BaseWrap  = LIN_W'(CELLS - COLUMNS);
  localparam logic [ROW_W-1:0] RowLast   = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]   ColEnd    = (COL_W + 1)'(COLUMNS);

  tccw_pkg::back_state_e state_q, state_d;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [LIN_W-1:0] lin_q, lin_d;
  // physical offset of the top screen row; scrolling rotates it
  logic [LIN_W-1:0] base_q, base_d;
  logic [LIN_W-1:0] clr_addr_q, clr_addr_d;
  logic [LIN_W-1:0] clr_last_q, clr_last_d;

  logic                out_valid_q, out_valid_d;
  tccw_pkg::out_item_t out_q, out_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] to_phys(input logic [LIN_W-1:0] lin,
                                            input logic [LIN_W-1:0] base);
    logic [LIN_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= CellCount) begin
      sum = sum - CellCount;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    logic           take;
    logic           emit;
    logic           nl;
    logic [COL_W:0] col_inc;
    logic [COL_W:0] tab_col;
    logic [COL_W:0] tab_step;

    take     = q_valid_i && (!out_valid_q || !out_stall_i);
    emit     = 1'b0;
    nl       = 1'b0;
    col_inc  = {1'b0, col_q} + 1'b1;
    tab_col  = ({1'b0, col_q} | (COL_W + 1)'(3)) + 1'b1;
    tab_step = tab_col - {1'b0, col_q};

    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    lin_d       = lin_q;
    base_d      = base_q;
    clr_addr_d  = clr_addr_q;
    clr_last_d  = clr_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q[AW-1:0];
    ram_wdata   = tccw_pkg::BLANK_CELL;
    ram_re      = 1'b0;
    ram_raddr   = to_phys(q_op_i.lin, base_q);

    unique case (state_q)
      tccw_pkg::BK_INIT, tccw_pkg::BK_SCROLL: begin
        ram_we = 1'b1;
        if (clr_addr_q == clr_last_q) begin
          state_d = tccw_pkg::BK_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      tccw_pkg::BK_IDLE: begin
        if (take) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          case (q_op_i.kind)
            tccw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = to_phys(lin_q, base_q);
              ram_wdata = {tccw_pkg::ATTR_NORMAL, q_op_i.char_code};
              if (col_inc == ColEnd) begin
                nl = 1'b1;
              end else begin
                col_d = col_inc[COL_W-1:0];
                lin_d = lin_q + 1'b1;
              end
            end
            tccw_pkg::OP_NEWLINE: begin
              nl = 1'b1;
            end
            tccw_pkg::OP_TAB: begin
              if (tab_col >= ColEnd) begin
                nl = 1'b1;
              end else begin
                col_d = tab_col[COL_W-1:0];
                lin_d = lin_q + LIN_W'(tab_step);
              end
            end
            tccw_pkg::OP_SEEK: begin
              col_d = q_op_i.col;
              row_d = q_op_i.row;
              lin_d = q_op_i.lin;
            end
            tccw_pkg::OP_READ: begin
              emit    = 1'b0;
              ram_re  = 1'b1;
              state_d = tccw_pkg::BK_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase

          if (nl) begin
            col_d = '0;
            if (row_q == RowLast) begin
              // scroll: old top row becomes the new bottom row, blank it
              row_d      = RowLast;
              lin_d      = BottomLin;
              base_d     = (base_q == BaseWrap) ? '0 : base_q + Cols;
              clr_addr_d = base_q;
              clr_last_d = base_q + Cols - 1'b1;
              state_d    = tccw_pkg::BK_SCROLL;
            end else begin
              row_d = row_q + 1'b1;
              lin_d = lin_q - LIN_W'(col_q) + Cols;
            end
          end

          if (emit) begin
            out_valid_d      = 1'b1;
            out_d.cursor_pos = lin_d[POS_W-1:0];
            out_d.read_data  = '0;
          end
        end
      end
      tccw_pkg::BK_READ: begin
        out_valid_d      = 1'b1;
        out_d.cursor_pos = lin_q[POS_W-1:0];
        out_d.read_data  = ram_rdata;
        state_d          = tccw_pkg::BK_IDLE;
      end
      default: begin
        state_d = tccw_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::BK_INIT;
      col_q       <= '0;
      row_q       <= '0;
      lin_q       <= '0;
      base_q      <= '0;
      clr_addr_q  <= '0;
      clr_last_q  <= CellLast;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      lin_q       <= lin_d;
      base_q      <= base_d;
      clr_addr_q  <= clr_addr_d;
      clr_last_q  <= clr_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  tccw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign init_done_o = (state_q != tccw_pkg::BK_INIT);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/text_console_cursor_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer_unit
// Text-mode console engine: character screen with cursor, put/seek/read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one command
//   per transfer: put a byte, seek the cursor, or read one screen cell.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one result per command, in order: the linear cursor position and, for
//   reads, the cell contents.
//   Commands are decoded into a two-entry queue; the execution side pops one
//   operation at a time. Put, seek and unused commands complete in its idle
//   state; reads also pass through the registered screen RAM read. A put, tab
//   or newline that runs off the last row keeps it busy while the rotated-out
//   row (COLUMNS cells) is blanked; the result itself is issued right away.
//   Each result leaves through the output register; a read result also passes
//   the screen RAM read register first.
//   After reset the screen RAM is swept to blank cells, one cell per cycle,
//   all ROWS*COLUMNS cells (2000 by default); in_stall_o stays high meanwhile.
//   A stalled result is held in the output register; the queue keeps taking
//   commands until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tccw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tccw_pkg::out_item_t out_item_o
);

  logic          init_done;
  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  tccw_pkg::op_t op_in;
  tccw_pkg::op_t op_out;

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .op_o        (op_in)
  );

  tccw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .op_o    (op_out)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (op_out),
    .pop_o       (q_pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // no command is taken while the screen is still being blanked
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> in_stall_o)
    else $error("input transfer possible during clearing pass");

  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !out_valid_o)
    else $error("result issued during clearing pass");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");

endmodule

[dv/tb_text_console_cursor_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_writer_unit
// Self-checking bench for the text console engine. A directed script covers
// reset contents, out-of-range reads, clamped seeks, tabs, newlines, line wrap
// and scrolling. A long random run of text, seeks, reads and unused commands
// follows, with random idle bursts on both channels. Every result is compared
// against a screen and cursor model kept inside the bench, or against a fixed reply for some scripted rows.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_writer_unit;

  localparam int unsigned CMD_W  = tccw_pkg::CMD_W;
  localparam int unsigned CHAR_W = tccw_pkg::CHAR_W;
  localparam int unsigned COL_W  = tccw_pkg::COL_W;
  localparam int unsigned ROW_W  = tccw_pkg::ROW_W;
  localparam int unsigned IDX_W  = tccw_pkg::IDX_W;
  localparam int unsigned POS_W  = tccw_pkg::POS_W;
  localparam int unsigned DATA_W = tccw_pkg::DATA_W;

  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned CELLS        = COLUMNS * ROWS;
  localparam int unsigned TAB_STOP     = 4;
  localparam int unsigned RAND_ITEMS   = 1700;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tccw_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tccw_pkg::out_item_t out_item_o;

  text_console_cursor_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // screen and cursor as the block should hold them
  logic [DATA_W-1:0] screen_model [CELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;

  tccw_pkg::out_item_t cursor_cell_q [$];

  typedef struct {
    tccw_pkg::in_item_t  cmd;
    bit                  has_reply;
    tccw_pkg::out_item_t reply;
  } script_row_t;
  script_row_t script [$];

  bit          idling = 1'b1;
  int unsigned stall_left = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned put_count = 0, seek_count = 0, read_count = 0, unused_count = 0;
  int unsigned scroll_count = 0, far_read_count = 0, reply_count = 0;

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = tccw_pkg::BLANK_CELL;
    cur_col = '0;
    cur_row = ROW_W'(ROWS - 1);
    scroll_count++;
  endfunction

  function automatic void next_row();
    cur_col = '0;
    cur_row = cur_row + 1'b1;
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  function automatic tccw_pkg::out_item_t apply_console_cmd(input tccw_pkg::in_item_t c);
    tccw_pkg::out_item_t res;
    int unsigned         at;
    res = '0;
    case (c.command)
      tccw_pkg::CMD_PUT: begin
        put_count++;
        if (c.char_code == tccw_pkg::CHAR_NEWLINE) begin
          next_row();
        end else if (c.char_code == tccw_pkg::CHAR_TAB) begin
          cur_col = COL_W'((cur_col / TAB_STOP + 1) * TAB_STOP);
          if (cur_col >= COLUMNS) next_row();
        end else begin
          at = cur_row * COLUMNS + cur_col;
          if (at < CELLS) screen_model[at] = {tccw_pkg::ATTR_NORMAL, c.char_code};
          cur_col = cur_col + 1'b1;
          if (cur_col >= COLUMNS) next_row();
        end
      end
      tccw_pkg::CMD_SEEK: begin
        seek_count++;
        cur_col = (c.seek_col < COLUMNS) ? c.seek_col : COL_W'(COLUMNS - 1);
        cur_row = (c.seek_row < ROWS) ? c.seek_row : ROW_W'(ROWS - 1);
      end
      tccw_pkg::CMD_READ: begin
        read_count++;
        if (c.cell_index < CELLS) res.read_data = screen_model[c.cell_index];
        else far_read_count++;
      end
      default: unused_count++;
    endcase
    at = cur_row * COLUMNS + cur_col;
    res.cursor_pos = POS_W'(at);
    return res;
  endfunction

  function automatic tccw_pkg::in_item_t cmd_of(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                                logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                                logic [IDX_W-1:0] idx);
    tccw_pkg::in_item_t c;
    c.command    = op;
    c.char_code  = ch;
    c.seek_col   = col;
    c.seek_row   = row;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic void add_row(tccw_pkg::in_item_t c, bit has_reply, int unsigned pos,
                                  logic [DATA_W-1:0] data);
    script_row_t r;
    r.cmd                = c;
    r.has_reply          = has_reply;
    r.reply.cursor_pos   = POS_W'(pos);
    r.reply.read_data    = data;
    script.push_back(r);
  endfunction

  // hold the command until the block takes it, then log what must come back
  task automatic issue_cmd(input tccw_pkg::in_item_t c, input bit has_reply,
                           input tccw_pkg::out_item_t reply);
    int unsigned         gap;
    tccw_pkg::out_item_t predicted;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_console_cmd(c);
    cursor_cell_q.push_back(has_reply ? reply : predicted);
  endtask

  // result side: check each transfer, throw in random stall bursts
  always @(posedge clk_i) begin
    tccw_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        reply_count++;
        if (cursor_cell_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, cursor_pos %0d read_data %h", $time,
                   out_item_o.cursor_pos, out_item_o.read_data);
        end else begin
          want = cursor_cell_q.pop_front();
          if (out_item_o.cursor_pos !== want.cursor_pos) begin
            err_count++;
            $display("%0t: cursor_pos expected %0d, actual %0d", $time,
                     want.cursor_pos, out_item_o.cursor_pos);
          end
          if (out_item_o.read_data !== want.read_data) begin
            err_count++;
            $display("%0t: read_data expected %h, actual %h", $time,
                     want.read_data, out_item_o.read_data);
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idling && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout, %0d results still awaited", $time, cursor_cell_q.size());
    $display("FAIL text_console_cursor_writer_unit");
    $finish;
  end

  initial begin
    tccw_pkg::in_item_t c;
    int unsigned        pick, lin, back;

    for (int i = 0; i < CELLS; i++) screen_model[i] = tccw_pkg::BLANK_CELL;
    cur_col = '0;
    cur_row = '0;

    // blank screen after reset, out-of-range reads, unused command, then puts, tabs and a newline
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, 0), 1, 0, tccw_pkg::BLANK_CELL);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, IDX_W'(CELLS - 1)), 1, 0,
            tccw_pkg::BLANK_CELL);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, IDX_W'(CELLS)), 1, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, '1), 1, 0, '0);
    add_row(cmd_of(CMD_UNUSED, '1, '1, '1, '1), 1, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, 8'h41, 0, 0, 0), 1, 1, '0);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, 0), 1, 1, {tccw_pkg::ATTR_NORMAL, 8'h41});
    add_row(cmd_of(tccw_pkg::CMD_PUT, 8'h00, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, 8'hFF, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_NEWLINE, 0, 0, 0), 0, 0, '0);
    // clamp to the last cell, then a byte there wraps and scrolls
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, '1, '1, 0), 1, CELLS - 1, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, 8'h5A, 0, 0, 0), 1, (ROWS - 1) * COLUMNS, '0);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, IDX_W'(CELLS - COLUMNS - 1)), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, IDX_W'(CELLS - 1)), 0, 0, '0);
    // tab and newline off the bottom row
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, COL_W'(COLUMNS - 4), ROW_W'(ROWS - 1), 0),
            0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_TAB, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, 0, ROW_W'(ROWS - 1), 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_NEWLINE, 0, 0, 0), 0, 0, '0);
    // column just past the edge, then line wrap without scroll
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, COL_W'(COLUMNS), 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_PUT, 8'h71, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, 0, 0, 0), 1, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_READ, 0, 0, 0, 0), 0, 0, '0);
    add_row(cmd_of(tccw_pkg::CMD_SEEK, 0, 0, ROW_W'(ROWS), 0), 0, 0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k]) issue_cmd(script[k].cmd, script[k].has_reply, script[k].reply);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idling = (i < RAND_ITEMS - CALM_TAIL) && ((i / 128) % 3 != 2);
      c.command    = CMD_W'($urandom);
      c.char_code  = CHAR_W'($urandom);
      c.seek_col   = COL_W'($urandom);
      c.seek_row   = ROW_W'($urandom);
      c.cell_index = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c.command = tccw_pkg::CMD_PUT;
        case ($urandom_range(0, 9))
          0: c.char_code = tccw_pkg::CHAR_NEWLINE;
          1: c.char_code = tccw_pkg::CHAR_TAB;
          default: ;
        endcase
      end else if (pick < 67) begin
        c.command = tccw_pkg::CMD_SEEK;
      end else if (pick < 96) begin
        c.command = tccw_pkg::CMD_READ;
        // mostly read back what was just written
        if ($urandom_range(0, 3) != 0) begin
          lin  = cur_row * COLUMNS + cur_col;
          back = $urandom_range(0, 2 * COLUMNS);
          c.cell_index = IDX_W'((lin >= back) ? lin - back : 0);
        end
      end else begin
        c.command = CMD_UNUSED;
      end
      issue_cmd(c, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    idling = 1'b0;

    while (cursor_cell_q.size() != 0) @(posedge clk_i);
    // a scroll may still be clearing the bottom row
    repeat (2 * COLUMNS) @(posedge clk_i);

    $display("Covered %0d commands: %0d puts, %0d seeks, %0d reads, %0d unused.",
             put_count + seek_count + read_count + unused_count,
             put_count, seek_count, read_count, unused_count);
    $display("%0d results checked, %0d scrolls, %0d reads past the screen end.",
             reply_count, scroll_count, far_read_count);
    if (err_count == 0) begin
      $display("PASS text_console_cursor_writer_unit");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL text_console_cursor_writer_unit");
    end
    $finish;
  end

endmodule
